[rtl/grs_pkg.sv]
`default_nettype none
package grs_pkg;

  // field widths
  localparam int MEAN_W   = 32;
  localparam int SIGMA_W  = 31;
  localparam int SAMPLE_W = 32;
  localparam int TRIALS_W = 10;
  localparam int SEED_W   = 32;

  // mt19937 constants
  localparam int          TW_N         = 624;
  localparam int          TW_M         = 397;
  localparam logic [31:0] MT_MAG       = 32'h9908_b0df;
  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  // controller states
  typedef enum logic [4:0] {
    ST_INIT0, ST_INIT_MUL, ST_INIT_WR, ST_IDLE,
    ST_DRAW_CHK, ST_DRAW_CAP, ST_RG_RD0, ST_RG_RD1, ST_RG_WR,
    ST_CAND_HI, ST_CAND_LO, ST_CAND_X, ST_DIST, ST_FAR, ST_DIV,
    ST_SQ, ST_SQ_CAP, ST_EXP_MUL, ST_EXP_LD, ST_EXP_DIV, ST_EXP_ACC, ST_EXP_END,
    ST_H_SQ, ST_H_CAP, ST_POW, ST_POW_CAP, ST_TEST, ST_FINISH
  } grs_state_t;

  // output tempering of one twister word
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

[rtl/grs_if.sv]
`default_nettype none
interface grs_req_if import grs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [MEAN_W-1:0]  mean_value;
  logic        [SIGMA_W-1:0] std_deviation;
  modport source (output valid, mean_value, std_deviation, input ready);
  modport sink   (input valid, mean_value, std_deviation, output ready);
endinterface

interface grs_res_if import grs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample_value;
  logic                        sampling_failed;
  logic        [TRIALS_W-1:0]  trials_used;
  modport source (output valid, sample_value, sampling_failed, trials_used, input ready);
  modport sink   (input valid, sample_value, sampling_failed, trials_used, output ready);
endinterface

interface grs_cfg_if import grs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/gaussian_rejection_sampler_top.sv]
`default_nettype none
// a trial skips the distance divider and the series when the candidate lies beyond 8 sigma;
//   otherwise it runs the bit-serial distance divider and then the 16-term exp series; a
//   request takes one to MAX_TRIES trials
// every 312 trials the twister table regenerates in place, reading and rewriting it word by word
// throughput: one request at a time; the next is taken while the result waits in its register
// reset and seed write: the table is refilled from the seed word by word, then exp(-1) is
//   worked out, with no request taken meanwhile
module gaussian_rejection_sampler_top import grs_pkg::*; #(
  parameter int MAX_TRIES  = 1000,
  parameter int FAIL_LIMIT = 997,
  parameter int FRAC_BITS  = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  grs_cfg_if.sink    cfg_ch,
  grs_req_if.sink    in_ch,
  grs_res_if.source  out_ch
);

  localparam int QB   = FRAC_BITS + 3;
  localparam int QCW  = $clog2(QB);
  localparam int TRW  = ($clog2(MAX_TRIES + 1) > TRIALS_W) ? $clog2(MAX_TRIES + 1) : TRIALS_W;
  localparam logic [TRW-1:0] MAX_T  = TRW'(MAX_TRIES);
  localparam logic [16:0]    FAIL_L = 17'(FAIL_LIMIT);
  localparam logic [9:0]     LAST_W = 10'(TW_N - 1);
  localparam logic [9:0]     POS_END = 10'(TW_N);
  localparam logic [9:0]     M_OFF = 10'(TW_M);

  // twister word store
  logic [31:0] twister_mem [TW_N];
  logic [31:0] rd_a_r, rd_b_r;
  logic [9:0]  ra_a, ra_b, wa;
  logic [31:0] wd;
  logic        we;

  always_ff @(posedge clk) begin
    if (we) twister_mem[wa] <= wd;
    rd_a_r <= twister_mem[ra_a];
    rd_b_r <= twister_mem[ra_b];
  end

  // shared multiplier, registered
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  grs_state_t state_r, state_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [9:0]  idx_r, idx_nxt, pos_r, pos_nxt;
  logic [31:0] p_r, p_nxt, e1_r, e1_nxt;
  logic        e1_mode_r, e1_mode_nxt, draw_sel_r, draw_sel_nxt;
  logic signed [31:0] mu_r, mu_nxt;
  logic [30:0] sigma_r, sigma_nxt;
  logic [33:0] lm_r, lm_nxt;
  logic [TRW-1:0] trials_r, trials_nxt;
  logic [31:0] test_r, test_nxt, rnd_r, rnd_nxt;
  logic [49:0] hi_r, hi_nxt;
  logic signed [36:0] x_r, x_nxt;
  logic [36:0] ad_r, ad_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [QB-1:0] dq_r, dq_nxt;
  logic [QCW-1:0] divc_r, divc_nxt;
  logic [4:0]  n_r, n_nxt, k_r, k_nxt;
  logic [31:0] f_r, f_nxt, term_r, term_nxt, dv_r, dv_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic [3:0]  drem_r, drem_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [32:0] g_r, g_nxt;
  logic [31:0] y0_r, y0_nxt, y1_r, y1_nxt;
  logic        out_valid_r, out_valid_nxt, out_failed_r, out_failed_nxt;
  logic signed [31:0] out_sample_r, out_sample_nxt;
  logic [TRIALS_W-1:0] out_trials_r, out_trials_nxt;

  assign cfg_ch.ready        = (state_r == ST_IDLE);
  assign in_ch.ready         = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = out_sample_r;
  assign out_ch.sampling_failed = out_failed_r;
  assign out_ch.trials_used  = out_trials_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT0;
      seed_r      <= SEED_RESET;
      pos_r       <= POS_END;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;       p_r <= p_nxt;           e1_r <= e1_nxt;
    e1_mode_r <= e1_mode_nxt; draw_sel_r <= draw_sel_nxt;
    mu_r <= mu_nxt;         sigma_r <= sigma_nxt;   lm_r <= lm_nxt;
    trials_r <= trials_nxt; test_r <= test_nxt;     rnd_r <= rnd_nxt;
    hi_r <= hi_nxt;         x_r <= x_nxt;           ad_r <= ad_nxt;
    rem_r <= rem_nxt;       dq_r <= dq_nxt;         divc_r <= divc_nxt;
    n_r <= n_nxt;           k_r <= k_nxt;           f_r <= f_nxt;
    term_r <= term_nxt;     dv_r <= dv_nxt;         sum_r <= sum_nxt;
    drem_r <= drem_nxt;     dcnt_r <= dcnt_nxt;     g_r <= g_nxt;
    y0_r <= y0_nxt;         y1_r <= y1_nxt;
    out_failed_r <= out_failed_nxt; out_sample_r <= out_sample_nxt;
    out_trials_r <= out_trials_nxt;
  end

  // sequencer
  always_comb begin
    logic [31:0] word, y, v;
    logic [50:0] cand_sum;
    logic [35:0] t;
    logic signed [36:0] xt;
    logic signed [37:0] d;
    logic [31:0] rr;
    logic        ge;
    logic [4:0]  r5;
    logic [3:0]  rm;
    logic [31:0] dvv;
    logic [63:0] rnd64;
    logic [TRW-1:0] tr1;
    logic        acc;

    state_nxt = state_r;   seed_nxt = seed_r;     idx_nxt = idx_r;   pos_nxt = pos_r;
    p_nxt = p_r;           e1_nxt = e1_r;         e1_mode_nxt = e1_mode_r;
    draw_sel_nxt = draw_sel_r; mu_nxt = mu_r;     sigma_nxt = sigma_r; lm_nxt = lm_r;
    trials_nxt = trials_r; test_nxt = test_r;     rnd_nxt = rnd_r;   hi_nxt = hi_r;
    x_nxt = x_r;           ad_nxt = ad_r;         rem_nxt = rem_r;   dq_nxt = dq_r;
    divc_nxt = divc_r;     n_nxt = n_r;           k_nxt = k_r;       f_nxt = f_r;
    term_nxt = term_r;     dv_nxt = dv_r;         sum_nxt = sum_r;   drem_nxt = drem_r;
    dcnt_nxt = dcnt_r;     g_nxt = g_r;           y0_nxt = y0_r;     y1_nxt = y1_r;
    out_valid_nxt = out_valid_r;  out_failed_nxt = out_failed_r;
    out_sample_nxt = out_sample_r; out_trials_nxt = out_trials_r;
    ra_a = pos_r; ra_b = idx_r; wa = idx_r; wd = 32'd0; we = 1'b0;
    mul_a = 32'd0; mul_b = 32'd0;
    word = 32'd0; y = 32'd0; v = 32'd0; cand_sum = 51'd0; t = 36'd0; xt = 37'sd0;
    d = 38'sd0; rr = 32'd0; ge = 1'b0; r5 = 5'd0; rm = 4'd0; dvv = 32'd0;
    rnd64 = prod_r + 64'h8000_0000; tr1 = trials_r + 1'b1; acc = 1'b0;

    // result register drains
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      // table fill from the seed
      ST_INIT0: begin
        we = 1'b1; wa = 10'd0; wd = seed_r;
        p_nxt = seed_r; idx_nxt = 10'd1; pos_nxt = POS_END;
        state_nxt = ST_INIT_MUL;
      end
      ST_INIT_MUL: begin
        mul_a = p_r ^ (p_r >> 30); mul_b = MT_INIT_MULT;
        state_nxt = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        word = prod_r[31:0] + {22'd0, idx_r};
        we = 1'b1; wa = idx_r; wd = word; p_nxt = word;
        if (idx_r == LAST_W) begin
          f_nxt = 32'h8000_0000; k_nxt = 5'd1; sum_nxt = 35'sh1_0000_0000;
          e1_mode_nxt = 1'b1; state_nxt = ST_EXP_MUL;
        end else begin
          idx_nxt = idx_r + 10'd1; state_nxt = ST_INIT_MUL;
        end
      end
      // waiting for a request or a seed write
      ST_IDLE: begin
        if (cfg_ch.valid) begin
          seed_nxt = cfg_ch.data; state_nxt = ST_INIT0;
        end else if (in_ch.valid) begin
          mu_nxt = in_ch.mean_value; sigma_nxt = in_ch.std_deviation;
          lm_nxt = (in_ch.mean_value[31] ? {2'b00, -in_ch.mean_value} :
                    {2'b00, in_ch.mean_value}) + {1'b0, in_ch.std_deviation, 2'b00};
          trials_nxt = '0; draw_sel_nxt = 1'b0; state_nxt = ST_DRAW_CHK;
        end
      end
      // uniform draw, regenerating the table when used up
      ST_DRAW_CHK: begin
        ra_a = pos_r;
        if (pos_r == POS_END) begin
          idx_nxt = 10'd0; state_nxt = ST_RG_RD0;
        end else begin
          state_nxt = ST_DRAW_CAP;
        end
      end
      ST_DRAW_CAP: begin
        word = temper(rd_a_r); pos_nxt = pos_r + 10'd1;
        if (!draw_sel_r) begin
          test_nxt = word; draw_sel_nxt = 1'b1; state_nxt = ST_DRAW_CHK;
        end else begin
          rnd_nxt = word; state_nxt = ST_CAND_HI;
        end
      end
      ST_RG_RD0: begin
        ra_a = idx_r; ra_b = (idx_r == LAST_W) ? 10'd0 : idx_r + 10'd1;
        state_nxt = ST_RG_RD1;
      end
      ST_RG_RD1: begin
        y0_nxt = rd_a_r; y1_nxt = rd_b_r;
        ra_a = (idx_r + M_OFF >= POS_END) ? idx_r + M_OFF - POS_END : idx_r + M_OFF;
        state_nxt = ST_RG_WR;
      end
      ST_RG_WR: begin
        y = {y0_r[31], y1_r[30:0]};
        v = rd_a_r ^ (y >> 1) ^ (y[0] ? MT_MAG : 32'd0);
        we = 1'b1; wa = idx_r; wd = v;
        if (idx_r == LAST_W) begin
          pos_nxt = 10'd0; state_nxt = ST_DRAW_CHK;
        end else begin
          idx_nxt = idx_r + 10'd1; state_nxt = ST_RG_RD0;
        end
      end
      // candidate from the second draw, in two partial products
      ST_CAND_HI: begin
        mul_a = {14'd0, lm_r[33:16]}; mul_b = rnd_r; state_nxt = ST_CAND_LO;
      end
      ST_CAND_LO: begin
        hi_nxt = prod_r[49:0];
        mul_a = {16'd0, lm_r[15:0]}; mul_b = rnd_r; state_nxt = ST_CAND_X;
      end
      ST_CAND_X: begin
        cand_sum = {1'b0, hi_r} + {19'd0, prod_r[47:16]};
        t = cand_sum[50:15];
        xt = $signed({1'b0, t}) - $signed({3'b000, lm_r});
        x_nxt = mu_r[31] ? -xt : xt;
        state_nxt = ST_DIST;
      end
      ST_DIST: begin
        d = 38'(x_r) - 38'(mu_r);
        ad_nxt = d[37] ? 37'(-d) : d[36:0];
        state_nxt = ST_FAR;
      end
      // beyond 8 sigma (or zero sigma) the weight is zero
      ST_FAR: begin
        if (ad_r >= {3'b000, sigma_r, 3'b000}) begin
          g_nxt = 33'd0; state_nxt = ST_TEST;
        end else begin
          rem_nxt = ad_r[33:3];
          dq_nxt = {ad_r[2:0], {FRAC_BITS{1'b0}}};
          divc_nxt = '0; state_nxt = ST_DIV;
        end
      end
      // restoring division, one quotient bit a cycle
      ST_DIV: begin
        rr = {rem_r, dq_r[QB-1]};
        ge = rr >= {1'b0, sigma_r};
        rem_nxt = ge ? 31'(rr - {1'b0, sigma_r}) : rr[30:0];
        dq_nxt = {dq_r[QB-2:0], ge};
        if (divc_r == QCW'(QB - 1)) state_nxt = ST_SQ;
        else divc_nxt = divc_r + 1'b1;
      end
      ST_SQ: begin
        mul_a = 32'(dq_r); mul_b = 32'(dq_r); state_nxt = ST_SQ_CAP;
      end
      ST_SQ_CAP: begin
        n_nxt = prod_r[2*FRAC_BITS+1 +: 5];
        f_nxt = {prod_r[FRAC_BITS+1 +: FRAC_BITS], {(32-FRAC_BITS){1'b0}}};
        k_nxt = 5'd1; sum_nxt = 35'sh1_0000_0000; e1_mode_nxt = 1'b0;
        state_nxt = ST_EXP_MUL;
      end
      // exp(-f) series, one term per pass
      ST_EXP_MUL: begin
        mul_a = term_r; mul_b = f_r; state_nxt = ST_EXP_LD;
      end
      ST_EXP_LD: begin
        dv_nxt = (k_r == 5'd1) ? f_r : prod_r[63:32];
        drem_nxt = 4'd0; dcnt_nxt = 2'd0; state_nxt = ST_EXP_DIV;
      end
      ST_EXP_DIV: begin
        rm = drem_r; dvv = dv_r;
        for (int j = 0; j < 8; j++) begin
          r5 = {rm, dvv[31]};
          if (r5 >= k_r) begin
            rm = 4'(r5 - k_r); dvv = {dvv[30:0], 1'b1};
          end else begin
            rm = r5[3:0]; dvv = {dvv[30:0], 1'b0};
          end
        end
        drem_nxt = rm; dv_nxt = dvv; dcnt_nxt = dcnt_r + 2'd1;
        if (dcnt_r == 2'd3) state_nxt = ST_EXP_ACC;
      end
      ST_EXP_ACC: begin
        term_nxt = dv_r;
        sum_nxt = k_r[0] ? sum_r - $signed({3'b000, dv_r}) : sum_r + $signed({3'b000, dv_r});
        if (k_r == 5'd16) state_nxt = ST_EXP_END;
        else begin
          k_nxt = k_r + 5'd1; state_nxt = ST_EXP_MUL;
        end
      end
      ST_EXP_END: begin
        if (sum_r < 0) g_nxt = 33'd0;
        else if (sum_r > 35'sh1_0000_0000) g_nxt = 33'h1_0000_0000;
        else g_nxt = sum_r[32:0];
        state_nxt = e1_mode_r ? ST_H_SQ : ST_POW;
      end
      // exp(-1) = round(exp(-0.5)^2)
      ST_H_SQ: begin
        mul_a = g_r[31:0]; mul_b = g_r[31:0]; state_nxt = ST_H_CAP;
      end
      ST_H_CAP: begin
        e1_nxt = rnd64[63:32]; state_nxt = ST_IDLE;
      end
      // integer part: n rounded multiplies by exp(-1)
      ST_POW: begin
        mul_a = g_r[31:0]; mul_b = e1_r;
        if (n_r == 5'd0) state_nxt = ST_TEST;
        else if (g_r[32]) begin
          g_nxt = {1'b0, e1_r}; n_nxt = n_r - 5'd1;
        end else state_nxt = ST_POW_CAP;
      end
      ST_POW_CAP: begin
        g_nxt = {1'b0, rnd64[63:32]}; n_nxt = n_r - 5'd1; state_nxt = ST_POW;
      end
      // acceptance test
      ST_TEST: begin
        acc = {1'b0, test_r} < g_r;
        trials_nxt = tr1;
        if (acc || tr1 == MAX_T) state_nxt = ST_FINISH;
        else begin
          draw_sel_nxt = 1'b0; state_nxt = ST_DRAW_CHK;
        end
      end
      // hand the result to the output register
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (x_r > 37'sh0_7fff_ffff) out_sample_nxt = 32'sh7fff_ffff;
          else if (x_r < -37'sh0_8000_0000) out_sample_nxt = 32'sh8000_0000;
          else out_sample_nxt = x_r[31:0];
          out_failed_nxt = 17'(trials_r) > FAIL_L;
          out_trials_nxt = trials_r[TRIALS_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/grs_checker.sv]
`default_nettype none
module grs_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        cfg_valid,
  input wire        cfg_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_sample,
  input wire        out_failed,
  input wire [9:0]  out_trials
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) &&
    $stable(out_failed) && $stable(out_trials))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("request taken while busy");

  // seed write starts the table fill
  a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready && !cfg_ready)
    else $error("request taken during table fill");

  // both channels open together when no seed write is pending
  a_idle_match: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |-> in_ready == cfg_ready)
    else $error("ready mismatch between request and seed ports");

endmodule

bind gaussian_rejection_sampler_top grs_checker u_grs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .cfg_valid  (cfg_ch.valid),
  .cfg_ready  (cfg_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_value),
  .out_failed (out_ch.sampling_failed),
  .out_trials (out_ch.trials_used)
);
`default_nettype wire

[test/gaussian_rejection_sampler_top_tb.sv]
`timescale 1ns / 1ps
module gaussian_rejection_sampler_top_tb;
  import grs_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [MEAN_W-1:0] mean;
    logic [SIGMA_W-1:0]       sigma;
  } sample_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       failed;
    logic [TRIALS_W-1:0]        trials;
  } sample_res_t;

  localparam int TRY_LIMIT  = 1000;
  localparam int FAIL_AFTER = 997;
  localparam int FRAC       = 16;
  localparam longint unsigned Q32_ONE = 64'd1 << 32;

  logic clk;
  logic rst_n;

  grs_req_if in_ch();
  grs_res_if out_ch();
  grs_cfg_if cfg_ch();

  gaussian_rejection_sampler_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sample_req_t pending_reqs[$];
  sample_res_t expected_samples[$];
  int          idle_pct = 23;
  int          error_count = 0;
  int          req_count = 0;
  int          res_count = 0;
  int          fail_flag_count = 0;
  int          seed_writes = 0;

  // twister copy used for prediction
  logic [31:0]     mt_words[TW_N];
  int              mt_pos;
  longint unsigned exp_m1;

  always #5 clk = ~clk;

  function automatic void mt_load_seed(logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int i = 1; i < TW_N; i++) begin
      p = mt_words[i-1];
      mt_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
    end
    mt_pos = TW_N;
  endfunction

  function automatic logic [31:0] mt_next_word();
    logic [31:0] y;
    logic [31:0] v;
    if (mt_pos >= TW_N) begin
      for (int i = 0; i < TW_N; i++) begin
        y = (mt_words[i] & 32'h8000_0000) | (mt_words[(i+1) % TW_N] & 32'h7fff_ffff);
        v = mt_words[(i+TW_M) % TW_N] ^ (y >> 1);
        if (y[0]) v = v ^ 32'h9908_b0df;
        mt_words[i] = v;
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // exp(-f), f in q0.32, by a 16-term alternating series
  function automatic longint unsigned exp_neg_q32(longint unsigned f);
    longint unsigned term;
    longint          acc;
    term = Q32_ONE;
    acc  = longint'(Q32_ONE);
    for (int k = 1; k <= 16; k++) begin
      term = ((term * f) >> 32) / u64_t'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q32_ONE)) acc = longint'(Q32_ONE);
    return u64_t'(acc);
  endfunction

  // acceptance threshold for candidate x
  function automatic longint unsigned gauss_threshold(longint x, longint mu,
                                                      longint unsigned sigma);
    longint          d;
    longint unsigned ad, zq, q, g;
    if (sigma == 0) return 0;
    d  = x - mu;
    ad = (d < 0) ? u64_t'(-d) : u64_t'(d);
    zq = (ad << FRAC) / sigma;
    if (zq >= (64'd8 << FRAC)) return 0;
    q = (zq * zq) >> (FRAC + 1);
    g = exp_neg_q32((q & ((64'd1 << FRAC) - 1)) << (32 - FRAC));
    for (longint unsigned i = 0; i < (q >> FRAC); i++)
      g = (g * exp_m1 + (64'd1 << 31)) >> 32;
    return g;
  endfunction

  function automatic sample_res_t draw_sample(sample_req_t r);
    sample_res_t     res;
    longint          mu, x;
    longint unsigned sigma, lm, test, rw, t;
    int              tries;
    mu    = longint'(r.mean);
    sigma = u64_t'(r.sigma);
    lm    = ((mu < 0) ? u64_t'(-mu) : u64_t'(mu)) + 4 * sigma;
    x     = 0;
    tries = 0;
    for (int i = 0; i < TRY_LIMIT; i++) begin
      test = u64_t'(mt_next_word());
      rw   = u64_t'(mt_next_word());
      t    = (((lm >> 16) * rw) + (((lm & 64'hffff) * rw) >> 16)) >> 15;
      tries++;
      x = longint'(t) - longint'(lm);
      if (mu < 0) x = -x;
      if (test < gauss_threshold(x, mu, sigma)) break;
    end
    if (x > 64'sh7fff_ffff) x = 64'sh7fff_ffff;
    if (x < -64'sh8000_0000) x = -64'sh8000_0000;
    res.sample = x[31:0];
    res.failed = (tries > FAIL_AFTER);
    res.trials = tries[TRIALS_W-1:0];
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sample_req_t acc;
        acc.mean  = in_ch.mean_value;
        acc.sigma = in_ch.std_deviation;
        expected_samples.push_back(draw_sample(acc));
        req_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          sample_req_t nxt;
          nxt = pending_reqs.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.mean_value    <= nxt.mean;
          in_ch.std_deviation <= nxt.sigma;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sample_res_t want;
        res_count++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result sample=%h failed=%b trials=%0d", $time,
                   out_ch.sample_value, out_ch.sampling_failed, out_ch.trials_used);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          if (want.failed) fail_flag_count++;
          if (out_ch.sample_value !== want.sample) begin
            $display("%0t: sample_value expected %h actual %h", $time, want.sample,
                     out_ch.sample_value);
            error_count++;
          end
          if (out_ch.sampling_failed !== want.failed) begin
            $display("%0t: sampling_failed expected %b actual %b", $time, want.failed,
                     out_ch.sampling_failed);
            error_count++;
          end
          if (out_ch.trials_used !== want.trials) begin
            $display("%0t: trials_used expected %0d actual %0d", $time, want.trials,
                     out_ch.trials_used);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic sample_req_t mk_req(logic [31:0] mu, logic [30:0] sigma);
    sample_req_t r;
    r.mean  = mu;
    r.sigma = sigma;
    return r;
  endfunction

  // mostly means within two sigma of zero, a few far-off means
  function automatic sample_req_t random_req();
    sample_req_t     r;
    longint          s, m;
    logic [30:0]     sg;
    sg = 31'($urandom) >> $urandom_range(30, 0);
    if (sg == 0) sg = 31'd1;
    s = longint'(sg);
    if ($urandom_range(99) < 2) begin
      m = longint'(int'($urandom));
    end else begin
      m = longint'({32'd0, $urandom}) % (4 * s + 1) - 2 * s;
      if (m > 64'sh7fff_ffff) m = 64'sh7fff_ffff;
      if (m < -64'sh8000_0000) m = -64'sh8000_0000;
    end
    r.mean  = m[31:0];
    r.sigma = sg;
    return r;
  endfunction

  task automatic drain_all();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_seed(logic [SEED_W-1:0] s);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= s;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    mt_load_seed(s);
    seed_writes++;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
    drain_all();
  endtask

  // stimulus sequence
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.mean_value = '0;
    in_ch.std_deviation = '0;
    out_ch.ready = 1'b0;
    exp_m1 = exp_neg_q32(64'd1 << 31);
    exp_m1 = (exp_m1 * exp_m1 + (64'd1 << 31)) >> 32;
    mt_load_seed(SEED_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners: extremes, zero sigma, saturation, far means
    pending_reqs.push_back(mk_req(32'h0000_0000, 31'h0001_0000));
    pending_reqs.push_back(mk_req(32'h0000_0000, 31'h7fff_ffff));
    pending_reqs.push_back(mk_req(32'h7fff_ffff, 31'h7fff_ffff));
    pending_reqs.push_back(mk_req(32'h8000_0000, 31'h7fff_ffff));
    pending_reqs.push_back(mk_req(32'h0000_0000, 31'h0000_0000));
    pending_reqs.push_back(mk_req(32'h8000_0000, 31'h0000_0000));
    pending_reqs.push_back(mk_req(32'h0000_0000, 31'h0000_0001));
    pending_reqs.push_back(mk_req(32'h8000_0000, 31'h0000_0001));
    pending_reqs.push_back(mk_req(32'h7fff_ffff, 31'h0000_0010));
    pending_reqs.push_back(mk_req(32'hffff_0000, 31'h0000_8000));
    pending_reqs.push_back(mk_req(32'h0003_0000, 31'h0001_0000));
    pending_reqs.push_back(mk_req(32'hfffd_0000, 31'h0001_0000));
    pending_reqs.push_back(mk_req(32'h4000_0000, 31'h4000_0000));
    pending_reqs.push_back(mk_req(32'hc000_0000, 31'h2000_0000));
    pending_reqs.push_back(mk_req(32'h5555_5555, 31'h2aaa_aaaa));
    pending_reqs.push_back(mk_req(32'haaaa_aaaa, 31'h5555_5555));
    pending_reqs.push_back(mk_req(32'h0000_0001, 31'h0000_0002));
    pending_reqs.push_back(mk_req(32'hffff_ffff, 31'h0000_0003));
    drain_all();

    write_seed(32'd0);
    random_phase(270);
    write_seed(32'hffff_ffff);
    idle_pct = 0;
    random_phase(270);
    idle_pct = 23;
    write_seed($urandom);
    random_phase(270);
    write_seed(SEED_RESET);
    random_phase(270);

    $display("covered %0d requests, %0d results, %0d flagged failures, %0d seed writes",
             req_count, res_count, fail_flag_count, seed_writes);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
